/* sv/assert_macros.svh */
// assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

/* sv/strumok_pkg.sv */
package strumok_pkg;

  localparam int InitRounds = 32;
  localparam int RoundCntW = 6;

  localparam logic [1:0] KIND_KEY = 2'd0;
  localparam logic [1:0] KIND_IV  = 2'd1;
  localparam logic [1:0] KIND_INIT = 2'd2;
  localparam logic [1:0] KIND_GEN = 2'd3;

  typedef struct packed {
    logic load_key;
    logic load_iv;
    logic seed;
    logic round;
    logic init_round;
    logic emit;
  } ctrl_t;

  localparam logic [7:0] SBOX0 [256] = '{
    8'ha8,8'h43,8'h5f,8'h06,8'h6b,8'h75,8'h6c,8'h59,8'h71,8'hdf,8'h87,8'h95,8'h17,8'hf0,8'hd8,8'h09,
    8'h6d,8'hf3,8'h1d,8'hcb,8'hc9,8'h4d,8'h2c,8'haf,8'h79,8'he0,8'h97,8'hfd,8'h6f,8'h4b,8'h45,8'h39,
    8'h3e,8'hdd,8'ha3,8'h4f,8'hb4,8'hb6,8'h9a,8'h0e,8'h1f,8'hbf,8'h15,8'he1,8'h49,8'hd2,8'h93,8'hc6,
    8'h92,8'h72,8'h9e,8'h61,8'hd1,8'h63,8'hfa,8'hee,8'hf4,8'h19,8'hd5,8'had,8'h58,8'ha4,8'hbb,8'ha1,
    8'hdc,8'hf2,8'h83,8'h37,8'h42,8'he4,8'h7a,8'h32,8'h9c,8'hcc,8'hab,8'h4a,8'h8f,8'h6e,8'h04,8'h27,
    8'h2e,8'he7,8'he2,8'h5a,8'h96,8'h16,8'h23,8'h2b,8'hc2,8'h65,8'h66,8'h0f,8'hbc,8'ha9,8'h47,8'h41,
    8'h34,8'h48,8'hfc,8'hb7,8'h6a,8'h88,8'ha5,8'h53,8'h86,8'hf9,8'h5b,8'hdb,8'h38,8'h7b,8'hc3,8'h1e,
    8'h22,8'h33,8'h24,8'h28,8'h36,8'hc7,8'hb2,8'h3b,8'h8e,8'h77,8'hba,8'hf5,8'h14,8'h9f,8'h08,8'h55,
    8'h9b,8'h4c,8'hfe,8'h60,8'h5c,8'hda,8'h18,8'h46,8'hcd,8'h7d,8'h21,8'hb0,8'h3f,8'h1b,8'h89,8'hff,
    8'heb,8'h84,8'h69,8'h3a,8'h9d,8'hd7,8'hd3,8'h70,8'h67,8'h40,8'hb5,8'hde,8'h5d,8'h30,8'h91,8'hb1,
    8'h78,8'h11,8'h01,8'he5,8'h00,8'h68,8'h98,8'ha0,8'hc5,8'h02,8'ha6,8'h74,8'h2d,8'h0b,8'ha2,8'h76,
    8'hb3,8'hbe,8'hce,8'hbd,8'hae,8'he9,8'h8a,8'h31,8'h1c,8'hec,8'hf1,8'h99,8'h94,8'haa,8'hf6,8'h26,
    8'h2f,8'hef,8'he8,8'h8c,8'h35,8'h03,8'hd4,8'h7f,8'hfb,8'h05,8'hc1,8'h5e,8'h90,8'h20,8'h3d,8'h82,
    8'hf7,8'hea,8'h0a,8'h0d,8'h7e,8'hf8,8'h50,8'h1a,8'hc4,8'h07,8'h57,8'hb8,8'h3c,8'h62,8'he3,8'hc8,
    8'hac,8'h52,8'h64,8'h10,8'hd0,8'hd9,8'h13,8'h0c,8'h12,8'h29,8'h51,8'hb9,8'hcf,8'hd6,8'h73,8'h8d,
    8'h81,8'h54,8'hc0,8'hed,8'h4e,8'h44,8'ha7,8'h2a,8'h85,8'h25,8'he6,8'hca,8'h7c,8'h8b,8'h56,8'h80};

  localparam logic [7:0] SBOX1 [256] = '{
    8'hce,8'hbb,8'heb,8'h92,8'hea,8'hcb,8'h13,8'hc1,8'he9,8'h3a,8'hd6,8'hb2,8'hd2,8'h90,8'h17,8'hf8,
    8'h42,8'h15,8'h56,8'hb4,8'h65,8'h1c,8'h88,8'h43,8'hc5,8'h5c,8'h36,8'hba,8'hf5,8'h57,8'h67,8'h8d,
    8'h31,8'hf6,8'h64,8'h58,8'h9e,8'hf4,8'h22,8'haa,8'h75,8'h0f,8'h02,8'hb1,8'hdf,8'h6d,8'h73,8'h4d,
    8'h7c,8'h26,8'h2e,8'hf7,8'h08,8'h5d,8'h44,8'h3e,8'h9f,8'h14,8'hc8,8'hae,8'h54,8'h10,8'hd8,8'hbc,
    8'h1a,8'h6b,8'h69,8'hf3,8'hbd,8'h33,8'hab,8'hfa,8'hd1,8'h9b,8'h68,8'h4e,8'h16,8'h95,8'h91,8'hee,
    8'h4c,8'h63,8'h8e,8'h5b,8'hcc,8'h3c,8'h19,8'ha1,8'h81,8'h49,8'h7b,8'hd9,8'h6f,8'h37,8'h60,8'hca,
    8'he7,8'h2b,8'h48,8'hfd,8'h96,8'h45,8'hfc,8'h41,8'h12,8'h0d,8'h79,8'he5,8'h89,8'h8c,8'he3,8'h20,
    8'h30,8'hdc,8'hb7,8'h6c,8'h4a,8'hb5,8'h3f,8'h97,8'hd4,8'h62,8'h2d,8'h06,8'ha4,8'ha5,8'h83,8'h5f,
    8'h2a,8'hda,8'hc9,8'h00,8'h7e,8'ha2,8'h55,8'hbf,8'h11,8'hd5,8'h9c,8'hcf,8'h0e,8'h0a,8'h3d,8'h51,
    8'h7d,8'h93,8'h1b,8'hfe,8'hc4,8'h47,8'h09,8'h86,8'h0b,8'h8f,8'h9d,8'h6a,8'h07,8'hb9,8'hb0,8'h98,
    8'h18,8'h32,8'h71,8'h4b,8'hef,8'h3b,8'h70,8'ha0,8'he4,8'h40,8'hff,8'hc3,8'ha9,8'he6,8'h78,8'hf9,
    8'h8b,8'h46,8'h80,8'h1e,8'h38,8'he1,8'hb8,8'ha8,8'he0,8'h0c,8'h23,8'h76,8'h1d,8'h25,8'h24,8'h05,
    8'hf1,8'h6e,8'h94,8'h28,8'h9a,8'h84,8'he8,8'ha3,8'h4f,8'h77,8'hd3,8'h85,8'he2,8'h52,8'hf2,8'h82,
    8'h50,8'h7a,8'h2f,8'h74,8'h53,8'hb3,8'h61,8'haf,8'h39,8'h35,8'hde,8'hcd,8'h1f,8'h99,8'hac,8'had,
    8'h72,8'h2c,8'hdd,8'hd0,8'h87,8'hbe,8'h5e,8'ha6,8'hec,8'h04,8'hc6,8'h03,8'h34,8'hfb,8'hdb,8'h59,
    8'hb6,8'hc2,8'h01,8'hf0,8'h5a,8'hed,8'ha7,8'h66,8'h21,8'h7f,8'h8a,8'h27,8'hc7,8'hc0,8'h29,8'hd7};

  localparam logic [7:0] SBOX2 [256] = '{
    8'h93,8'hd9,8'h9a,8'hb5,8'h98,8'h22,8'h45,8'hfc,8'hba,8'h6a,8'hdf,8'h02,8'h9f,8'hdc,8'h51,8'h59,
    8'h4a,8'h17,8'h2b,8'hc2,8'h94,8'hf4,8'hbb,8'ha3,8'h62,8'he4,8'h71,8'hd4,8'hcd,8'h70,8'h16,8'he1,
    8'h49,8'h3c,8'hc0,8'hd8,8'h5c,8'h9b,8'had,8'h85,8'h53,8'ha1,8'h7a,8'hc8,8'h2d,8'he0,8'hd1,8'h72,
    8'ha6,8'h2c,8'hc4,8'he3,8'h76,8'h78,8'hb7,8'hb4,8'h09,8'h3b,8'h0e,8'h41,8'h4c,8'hde,8'hb2,8'h90,
    8'h25,8'ha5,8'hd7,8'h03,8'h11,8'h00,8'hc3,8'h2e,8'h92,8'hef,8'h4e,8'h12,8'h9d,8'h7d,8'hcb,8'h35,
    8'h10,8'hd5,8'h4f,8'h9e,8'h4d,8'ha9,8'h55,8'hc6,8'hd0,8'h7b,8'h18,8'h97,8'hd3,8'h36,8'he6,8'h48,
    8'h56,8'h81,8'h8f,8'h77,8'hcc,8'h9c,8'hb9,8'he2,8'hac,8'hb8,8'h2f,8'h15,8'ha4,8'h7c,8'hda,8'h38,
    8'h1e,8'h0b,8'h05,8'hd6,8'h14,8'h6e,8'h6c,8'h7e,8'h66,8'hfd,8'hb1,8'he5,8'h60,8'haf,8'h5e,8'h33,
    8'h87,8'hc9,8'hf0,8'h5d,8'h6d,8'h3f,8'h88,8'h8d,8'hc7,8'hf7,8'h1d,8'he9,8'hec,8'hed,8'h80,8'h29,
    8'h27,8'hcf,8'h99,8'ha8,8'h50,8'h0f,8'h37,8'h24,8'h28,8'h30,8'h95,8'hd2,8'h3e,8'h5b,8'h40,8'h83,
    8'hb3,8'h69,8'h57,8'h1f,8'h07,8'h1c,8'h8a,8'hbc,8'h20,8'heb,8'hce,8'h8e,8'hab,8'hee,8'h31,8'ha2,
    8'h73,8'hf9,8'hca,8'h3a,8'h1a,8'hfb,8'h0d,8'hc1,8'hfe,8'hfa,8'hf2,8'h6f,8'hbd,8'h96,8'hdd,8'h43,
    8'h52,8'hb6,8'h08,8'hf3,8'hae,8'hbe,8'h19,8'h89,8'h32,8'h26,8'hb0,8'hea,8'h4b,8'h64,8'h84,8'h82,
    8'h6b,8'hf5,8'h79,8'hbf,8'h01,8'h5f,8'h75,8'h63,8'h1b,8'h23,8'h3d,8'h68,8'h2a,8'h65,8'he8,8'h91,
    8'hf6,8'hff,8'h13,8'h58,8'hf1,8'h47,8'h0a,8'h7f,8'hc5,8'ha7,8'he7,8'h61,8'h5a,8'h06,8'h46,8'h44,
    8'h42,8'h04,8'ha0,8'hdb,8'h39,8'h86,8'h54,8'haa,8'h8c,8'h34,8'h21,8'h8b,8'hf8,8'h0c,8'h74,8'h67};

  localparam logic [7:0] SBOX3 [256] = '{
    8'h68,8'h8d,8'hca,8'h4d,8'h73,8'h4b,8'h4e,8'h2a,8'hd4,8'h52,8'h26,8'hb3,8'h54,8'h1e,8'h19,8'h1f,
    8'h22,8'h03,8'h46,8'h3d,8'h2d,8'h4a,8'h53,8'h83,8'h13,8'h8a,8'hb7,8'hd5,8'h25,8'h79,8'hf5,8'hbd,
    8'h58,8'h2f,8'h0d,8'h02,8'hed,8'h51,8'h9e,8'h11,8'hf2,8'h3e,8'h55,8'h5e,8'hd1,8'h16,8'h3c,8'h66,
    8'h70,8'h5d,8'hf3,8'h45,8'h40,8'hcc,8'he8,8'h94,8'h56,8'h08,8'hce,8'h1a,8'h3a,8'hd2,8'he1,8'hdf,
    8'hb5,8'h38,8'h6e,8'h0e,8'he5,8'hf4,8'hf9,8'h86,8'he9,8'h4f,8'hd6,8'h85,8'h23,8'hcf,8'h32,8'h99,
    8'h31,8'h14,8'hae,8'hee,8'hc8,8'h48,8'hd3,8'h30,8'ha1,8'h92,8'h41,8'hb1,8'h18,8'hc4,8'h2c,8'h71,
    8'h72,8'h44,8'h15,8'hfd,8'h37,8'hbe,8'h5f,8'haa,8'h9b,8'h88,8'hd8,8'hab,8'h89,8'h9c,8'hfa,8'h60,
    8'hea,8'hbc,8'h62,8'h0c,8'h24,8'ha6,8'ha8,8'hec,8'h67,8'h20,8'hdb,8'h7c,8'h28,8'hdd,8'hac,8'h5b,
    8'h34,8'h7e,8'h10,8'hf1,8'h7b,8'h8f,8'h63,8'ha0,8'h05,8'h9a,8'h43,8'h77,8'h21,8'hbf,8'h27,8'h09,
    8'hc3,8'h9f,8'hb6,8'hd7,8'h29,8'hc2,8'heb,8'hc0,8'ha4,8'h8b,8'h8c,8'h1d,8'hfb,8'hff,8'hc1,8'hb2,
    8'h97,8'h2e,8'hf8,8'h65,8'hf6,8'h75,8'h07,8'h04,8'h49,8'h33,8'he4,8'hd9,8'hb9,8'hd0,8'h42,8'hc7,
    8'h6c,8'h90,8'h00,8'h8e,8'h6f,8'h50,8'h01,8'hc5,8'hda,8'h47,8'h3f,8'hcd,8'h69,8'ha2,8'he2,8'h7a,
    8'ha7,8'hc6,8'h93,8'h0f,8'h0a,8'h06,8'he6,8'h2b,8'h96,8'ha3,8'h1c,8'haf,8'h6a,8'h12,8'h84,8'h39,
    8'he7,8'hb0,8'h82,8'hf7,8'hfe,8'h9d,8'h87,8'h5c,8'h81,8'h35,8'hde,8'hb4,8'ha5,8'hfc,8'h80,8'hef,
    8'hcb,8'hbb,8'h6b,8'h76,8'hba,8'h5a,8'h7d,8'h78,8'h0b,8'h95,8'he3,8'had,8'h74,8'h98,8'h3b,8'h36,
    8'h64,8'h6d,8'hdc,8'hf0,8'h59,8'ha9,8'h4c,8'h17,8'h7f,8'h91,8'hb8,8'hc9,8'h57,8'h1b,8'he0,8'h61};

  localparam logic [7:0] MDS_ROW [8] = '{8'h01,8'h01,8'h05,8'h01,8'h08,8'h06,8'h07,8'h04};
  localparam logic [7:0] ALPHA_COEF [8] = '{8'h9f,8'hd5,8'h2c,8'hbe,8'h81,8'h1a,8'h4b,8'hcf};
  // alpha^-1 coefficients: alpha_coef[1..7], then 1
  localparam logic [7:0] ALPHA_INV_COEF [8] =
    '{8'hd5,8'h2c,8'hbe,8'h81,8'h1a,8'h4b,8'hcf,8'h01};

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1d : 8'h00);
    end
    return p;
  endfunction

  // inverse of alpha_coef[0] in the field
  function automatic logic [7:0] inv0();
    logic [7:0] r;
    r = 8'h00;
    for (int k = 255; k >= 1; k--) begin
      if (gf_mul(ALPHA_COEF[0], 8'(k)) == 8'h01) r = 8'(k);
    end
    return r;
  endfunction

  localparam logic [7:0] ALPHA_INV0 = inv0();

  function automatic logic [63:0] scale_alpha(input logic [7:0] b);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) r[8*i +: 8] = gf_mul(b, ALPHA_COEF[i]);
    return r;
  endfunction

  function automatic logic [63:0] scale_alpha_inv(input logic [7:0] b);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) r[8*i +: 8] = gf_mul(b, ALPHA_INV_COEF[i]);
    return r;
  endfunction

  function automatic logic [7:0] sbox(input logic [1:0] n, input logic [7:0] x);
    logic [7:0] r;
    case (n)
      2'd0: r = SBOX0[x];
      2'd1: r = SBOX1[x];
      2'd2: r = SBOX2[x];
      default: r = SBOX3[x];
    endcase
    return r;
  endfunction

  function automatic logic [63:0] t_map(input logic [63:0] x);
    logic [63:0] r;
    logic [7:0] p;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      p = sbox(2'(i), x[8*i +: 8]);
      for (int j = 0; j < 8; j++) r[8*j +: 8] = r[8*j +: 8] ^ gf_mul(MDS_ROW[(i - j) & 7], p);
    end
    return r;
  endfunction

  function automatic logic [63:0] mul_alpha(input logic [63:0] x);
    return {x[55:0], 8'h00} ^ scale_alpha(x[63:56]);
  endfunction

  function automatic logic [63:0] mul_alpha_inv(input logic [63:0] x);
    return {8'h00, x[63:8]} ^ scale_alpha_inv(gf_mul(x[7:0], ALPHA_INV0));
  endfunction

endpackage

/* sv/strumok_ctrl.sv */
module strumok_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_kind,
  input  logic              out_full,
  input  logic              out_taken,
  output logic              in_ready,
  output strumok_pkg::ctrl_t ctrl
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_INIT  = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [strumok_pkg::RoundCntW-1:0] count;
  logic [strumok_pkg::RoundCntW-1:0] count_next;
  logic accept;

  assign in_ready = (state == ST_IDLE) && (!out_full || out_taken);
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    count_next = count;
    ctrl = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            strumok_pkg::KIND_KEY: ctrl.load_key = 1'b1;
            strumok_pkg::KIND_IV: ctrl.load_iv = 1'b1;
            strumok_pkg::KIND_INIT: begin
              ctrl.seed = 1'b1;
              state_next = ST_INIT;
              count_next = '0;
            end
            default: begin
              ctrl.emit = 1'b1;
              ctrl.round = 1'b1;
            end
          endcase
        end
      end
      ST_INIT: begin
        ctrl.round = 1'b1;
        ctrl.init_round = 1'b1;
        count_next = count + 1'b1;
        if (count == strumok_pkg::RoundCntW'(strumok_pkg::InitRounds - 1)) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        ctrl.round = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

endmodule

/* sv/strumok_dp.sv */
module strumok_dp (
  input  logic               clk,
  input  logic               rst,
  input  strumok_pkg::ctrl_t ctrl,
  input  logic               key_mode,
  input  logic [2:0]         word_index,
  input  logic [63:0]        data_word,
  input  logic               out_taken,
  output logic               out_full,
  output logic [63:0]        out_word
);

  logic [63:0] cells [16];
  logic [63:0] r1;
  logic [63:0] r2;
  logic [63:0] key_buf [8];
  logic [63:0] iv_buf [4];
  logic [63:0] fsm_o;
  logic [63:0] fb;
  logic [63:0] seed [16];
  logic [63:0] k [8];
  logic [63:0] v [4];

  assign fsm_o = (cells[15] + r1) ^ r2;
  assign fb = strumok_pkg::mul_alpha(cells[0]) ^ strumok_pkg::mul_alpha_inv(cells[11])
            ^ cells[13] ^ (ctrl.init_round ? fsm_o : 64'h0);

  always_comb begin
    for (int i = 0; i < 4; i++) v[i] = iv_buf[3 - i];
    for (int i = 0; i < 8; i++) k[i] = key_mode ? key_buf[7 - i] : key_buf[(3 - i) & 7];
    if (!key_mode) begin
      seed[0] = k[3] ^ v[0];  seed[1] = k[2];
      seed[2] = k[1] ^ v[1];  seed[3] = k[0] ^ v[2];
      seed[4] = k[3];         seed[5] = k[2] ^ v[3];
      seed[6] = ~k[1];        seed[7] = ~k[0];
      seed[8] = k[3];         seed[9] = k[2];
      seed[10] = ~k[1];       seed[11] = k[0];
      seed[12] = k[3];        seed[13] = ~k[2];
      seed[14] = k[1];        seed[15] = ~k[0];
    end else begin
      seed[0] = k[7] ^ v[0];  seed[1] = k[6];
      seed[2] = k[5];         seed[3] = k[4] ^ v[1];
      seed[4] = k[3];         seed[5] = k[2] ^ v[2];
      seed[6] = k[1];         seed[7] = ~k[0];
      seed[8] = k[4] ^ v[3];  seed[9] = ~k[6];
      seed[10] = k[5];        seed[11] = ~k[7];
      seed[12] = k[3];        seed[13] = k[2];
      seed[14] = ~k[1];       seed[15] = k[0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_key) key_buf[word_index] <= data_word;
    if (ctrl.load_iv && !word_index[2]) iv_buf[word_index[1:0]] <= data_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) cells[i] <= '0;
      r1 <= '0;
      r2 <= '0;
      out_full <= 1'b0;
    end else begin
      if (ctrl.seed) begin
        for (int i = 0; i < 16; i++) cells[i] <= seed[i];
        r1 <= '0;
        r2 <= '0;
      end else if (ctrl.round) begin
        for (int i = 0; i < 15; i++) cells[i] <= cells[i + 1];
        cells[15] <= fb;
        r1 <= r2 + cells[13];
        r2 <= strumok_pkg::t_map(r1);
      end
      if (ctrl.emit) out_full <= 1'b1;
      else if (out_taken) out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) out_word <= fsm_o ^ cells[0];
  end

endmodule

/* sv/strumok_keystream_generator_core.sv */
// loads write on acceptance; keystream word valid the cycle after a generate request
// initialize: seed load, 32 init rounds, one normal round
// throughput: one word per cycle (single round unit) unless the output or init stalls
// reset: rst synchronous active high clears lfsr, fsm registers and key_mode
// key and iv buffers are not reset
module strumok_keystream_generator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // word_index[2:0], data_word[66:3], zero pad
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // keystream_word[63:0]
);

  strumok_pkg::ctrl_t ctrl;
  logic key_mode;
  logic out_taken;

  assign cfg_ready = 1'b1;
  assign out_taken = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) key_mode <= 1'b0;
    else if (cfg_valid) key_mode <= cfg_data;
  end

  strumok_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_kind(s_axis_tuser),
    .out_full(m_axis_tvalid), .out_taken(out_taken), .in_ready(s_axis_tready), .ctrl(ctrl)
  );

  strumok_dp u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .key_mode(key_mode),
    .word_index(s_axis_tdata[2:0]), .data_word(s_axis_tdata[66:3]),
    .out_taken(out_taken), .out_full(m_axis_tvalid), .out_word(m_axis_tdata)
  );

`include "assert_macros.svh"

  `ASSERT_CLK(a_emit_only_gen, clk, rst, ctrl.emit |-> (s_axis_tuser == strumok_pkg::KIND_GEN))
  `ASSERT_CLK(a_no_accept_full, clk, rst, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
  `ASSERT_CLK(a_emit_sets_valid, clk, rst, ctrl.emit |=> m_axis_tvalid)

endmodule

/* tb/sv/strumok_checker.sv */
`timescale 1ns / 1ps
module strumok_checker
  import strumok_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // word_index[2:0], data_word[66:3], zero pad
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,  // keystream_word[63:0]
  output int          errors,
  output int          pending,
  output int          checked
);

  logic [63:0] cells [16];
  logic [63:0] r1, r2;
  logic [63:0] keys [8];
  logic [63:0] ivs [4];
  logic        mode;
  logic [63:0] ks_expect [$];

  function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [8:0] t;
    acc = 8'h00;
    t = {1'b0, a};
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ t[7:0];
      t = {t[7:0], 1'b0};
      if (t[8]) t = t ^ 9'h11d;
    end
    return acc;
  endfunction

  function automatic logic [7:0] sub_byte(input int n, input logic [7:0] x);
    case (n)
      0: return SBOX0[x];
      1: return SBOX1[x];
      2: return SBOX2[x];
      default: return SBOX3[x];
    endcase
  endfunction

  function automatic logic [63:0] nonlinear(input logic [63:0] x);
    logic [63:0] acc;
    logic [7:0] p;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      p = sub_byte(i % 4, x[8*i +: 8]);
      for (int r = 0; r < 8; r++)
        acc[8*r +: 8] = acc[8*r +: 8] ^ fmul(MDS_ROW[(i - r + 8) % 8], p);
    end
    return acc;
  endfunction

  function automatic logic [63:0] times_alpha(input logic [63:0] x);
    logic [63:0] acc;
    acc = x << 8;
    for (int i = 0; i < 8; i++)
      acc[8*i +: 8] = acc[8*i +: 8] ^ fmul(x[63:56], ALPHA_COEF[i]);
    return acc;
  endfunction

  function automatic logic [63:0] div_alpha(input logic [63:0] x);
    logic [63:0] acc;
    logic [7:0] inv, b, c;
    inv = 8'h00;
    for (int k = 255; k >= 1; k--)
      if (fmul(ALPHA_COEF[0], 8'(k)) == 8'h01) inv = 8'(k);
    b = fmul(x[7:0], inv);
    acc = x >> 8;
    for (int i = 0; i < 8; i++) begin
      c = (i == 7) ? 8'h01 : ALPHA_COEF[i + 1];
      acc[8*i +: 8] = acc[8*i +: 8] ^ fmul(b, c);
    end
    return acc;
  endfunction

  function automatic void advance(input bit init_mode);
    logic [63:0] fb, n1, n2;
    fb = times_alpha(cells[0]) ^ div_alpha(cells[11]) ^ cells[13];
    n2 = nonlinear(r1);
    n1 = r2 + cells[13];
    if (init_mode) fb = fb ^ ((cells[15] + r1) ^ r2);
    for (int i = 0; i < 15; i++) cells[i] = cells[i + 1];
    cells[15] = fb;
    r1 = n1;
    r2 = n2;
  endfunction

  function automatic void seed_and_warm();
    logic [63:0] k [8];
    logic [63:0] v [4];
    for (int i = 0; i < 4; i++) v[i] = ivs[3 - i];
    if (!mode) begin
      for (int i = 0; i < 4; i++) k[i] = keys[3 - i];
      cells[0] = k[3] ^ v[0];  cells[1] = k[2];
      cells[2] = k[1] ^ v[1];  cells[3] = k[0] ^ v[2];
      cells[4] = k[3];         cells[5] = k[2] ^ v[3];
      cells[6] = ~k[1];        cells[7] = ~k[0];
      cells[8] = k[3];         cells[9] = k[2];
      cells[10] = ~k[1];       cells[11] = k[0];
      cells[12] = k[3];        cells[13] = ~k[2];
      cells[14] = k[1];        cells[15] = ~k[0];
    end else begin
      for (int i = 0; i < 8; i++) k[i] = keys[7 - i];
      cells[0] = k[7] ^ v[0];  cells[1] = k[6];
      cells[2] = k[5];         cells[3] = k[4] ^ v[1];
      cells[4] = k[3];         cells[5] = k[2] ^ v[2];
      cells[6] = k[1];         cells[7] = ~k[0];
      cells[8] = k[4] ^ v[3];  cells[9] = ~k[6];
      cells[10] = k[5];        cells[11] = ~k[7];
      cells[12] = k[3];        cells[13] = k[2];
      cells[14] = ~k[1];       cells[15] = k[0];
    end
    r1 = '0;
    r2 = '0;
    for (int i = 0; i < InitRounds; i++) advance(1'b1);
    advance(1'b0);
  endfunction

  assign pending = ks_expect.size();

  always @(posedge clk) begin
    logic [63:0] want;
    logic [2:0] idx;
    logic [63:0] dw;
    if (rst) begin
      for (int i = 0; i < 16; i++) cells[i] = '0;
      for (int i = 0; i < 8; i++) keys[i] = '0;
      for (int i = 0; i < 4; i++) ivs[i] = '0;
      r1 = '0;
      r2 = '0;
      mode = 1'b0;
      ks_expect.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (ks_expect.size() == 0) begin
          $error("unexpected keystream word %h", m_axis_tdata);
          errors++;
        end else begin
          want = ks_expect.pop_front();
          checked++;
          if (m_axis_tdata !== want) begin
            $error("keystream_word: expected %h, got %h", want, m_axis_tdata);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) mode = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        idx = s_axis_tdata[2:0];
        dw = s_axis_tdata[66:3];
        case (s_axis_tuser)
          KIND_KEY: keys[idx] = dw;
          KIND_IV: if (idx < 4) ivs[idx[1:0]] = dw;
          KIND_INIT: seed_and_warm();
          default: begin
            ks_expect.push_back(((cells[15] + r1) ^ r2) ^ cells[0]);
            advance(1'b0);
          end
        endcase
      end
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import strumok_pkg::*;

  localparam int Limit = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;  // word_index[2:0], data_word[66:3], zero pad
  logic [1:0]  s_axis_tuser = '0;  // kind[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;       // keystream_word[63:0]

  int errors, pending, checked;
  int snd_idle = 0;
  int rcv_idle = 0;
  bit hold = 0;
  bit cur_mode = 0;
  int requests = 0;
  int quiet = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  strumok_keystream_generator_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  strumok_checker chk (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .errors(errors), .pending(pending), .checked(checked)
  );

  always @(posedge clk) begin
    if (hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= Limit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic send(input logic [1:0] kind, input logic [2:0] idx, input logic [63:0] dw);
    while ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {5'b0, dw, idx};
    do @(posedge clk); while (!s_axis_tready);
    requests++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_mode(input bit m);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_mode = m;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic run_random(input int n);
    int start, nk, rot, ng;
    start = requests;
    while (requests - start < n) begin
      if ($urandom_range(9) < 8) begin
        nk = cur_mode ? 8 : 4;
        rot = $urandom_range(nk - 1);
        for (int i = 0; i < nk; i++) send(KIND_KEY, 3'((i + rot) % nk), rand64());
        for (int i = 0; i < 4; i++) send(KIND_IV, 3'((i + rot) % 4), rand64());
        if ($urandom_range(3) == 0) send(KIND_IV, 3'($urandom_range(7, 4)), rand64());
        send(KIND_INIT, 3'($urandom_range(7)), rand64());
        ng = $urandom_range(30, 3);
        for (int i = 0; i < ng; i++) send(KIND_GEN, 3'($urandom_range(7)), rand64());
      end else begin
        send(2'($urandom_range(3)), 3'($urandom_range(7)), rand64());
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // generate from the all-zero reset state
    send(KIND_GEN, 3'd0, '0);
    send(KIND_GEN, 3'd7, '1);
    for (int i = 0; i < 8; i++)
      send(KIND_KEY, 3'(i), (i % 2) ? 64'hffff_ffff_ffff_ffff : 64'h0);
    send(KIND_IV, 3'd0, '1);
    send(KIND_IV, 3'd1, '0);
    send(KIND_IV, 3'd2, 64'haaaa_aaaa_5555_5555);
    send(KIND_IV, 3'd3, 64'h8000_0000_0000_0001);
    send(KIND_IV, 3'd6, '1);
    send(KIND_INIT, 3'd0, '0);
    send(KIND_GEN, 3'd0, '0);
    send(KIND_GEN, 3'd0, '0);
    set_mode(1'b1);
    send(KIND_INIT, 3'd0, '0);
    send(KIND_GEN, 3'd0, '0);
    send(KIND_GEN, 3'd0, '0);
    set_mode(1'b0);
    // upper key words are unused in this mode
    send(KIND_KEY, 3'd5, rand64());
    send(KIND_INIT, 3'd0, '0);
    send(KIND_GEN, 3'd0, '0);

    set_mode(1'b1);
    snd_idle = 0;
    rcv_idle = 0;
    fork
      begin
        hold = 1;
        repeat (400) @(posedge clk);
        hold = 0;
      end
    join_none
    run_random(310);
    // sender waits for every outstanding word
    settle();
    snd_idle = 45;
    run_random(310);
    set_mode(1'b0);
    snd_idle = 0;
    rcv_idle = 45;
    run_random(310);
    set_mode(1'b1);
    snd_idle = 18;
    rcv_idle = 18;
    run_random(310);

    settle();
    $display("tb: %0d requests sent, %0d keystream words compared", requests, checked);
    $display("tb: both key sizes, four idle patterns, one long output stall");
    if (errors == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
